>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of the flow key extractor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk_i, off while rst_ni is low.
`define FKX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication built on the macro above.
`define FKX_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  `FKX_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> hdl/fkx_pkg.sv
// Package: types, constants and helpers of the flow key extractor.
package fkx_pkg;

  localparam int COUNT_BITS = 16;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  localparam cnt_t CNT_MAX = '1;

  localparam int ETH_HDR_LEN = 14;
  localparam int MAC_LEN     = 6;
  localparam int WORD_BYTES  = 4;
  localparam int POS_TYPE_HI = 12;
  localparam int POS_TYPE_LO = 13;

  // IPv4 byte offsets within the frame
  localparam int V4_PROTO = 23;
  localparam int V4_SRC   = 26;
  localparam int V4_DST   = 30;
  localparam int V4_END   = 34;

  // IPv6 byte offsets within the frame
  localparam int V6_PROTO  = 20;
  localparam int V6_SRC_HI = 22;
  localparam int V6_SRC_LO = 30;
  localparam int V6_DST_HI = 38;
  localparam int V6_DST_LO = 46;
  localparam int IPV6_PORTS = 54;

  localparam logic [15:0] TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] TYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [15:0] LEN_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } fkx_byte_t;

  typedef struct packed {
    cnt_t        pos;
    logic [15:0] eth_type;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [15:0] sport;
    logic [15:0] dport;
    logic        ports_done;
  } fkx_state_t;

  typedef struct packed {
    logic [15:0] net_type;
    logic [7:0]  transport_proto;
    logic [63:0] source_upper;
    logic [63:0] source_lower;
    logic [63:0] dest_upper;
    logic [63:0] dest_lower;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] frame_length;
    logic        header_short;
  } fkx_key_t;

  // Byte position inside an inclusive window
  function automatic logic in_window(cnt_t pos, int lo, int hi);
    in_window = (pos >= cnt_t'(lo)) && (pos <= cnt_t'(hi));
  endfunction

endpackage

>>> hdl/fkx_ifs.sv
// Channel interfaces: frame byte stream in, flow key transactions out.
interface fkx_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface fkx_key_if;
  logic        valid;
  logic        ready;
  logic [15:0] net_type;
  logic [7:0]  transport_proto;
  logic [63:0] source_upper;
  logic [63:0] source_lower;
  logic [63:0] dest_upper;
  logic [63:0] dest_lower;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [15:0] frame_length;
  logic        header_short;

  modport source (
    output valid, output net_type, output transport_proto,
    output source_upper, output source_lower, output dest_upper, output dest_lower,
    output source_port, output dest_port, output frame_length, output header_short,
    input ready
  );
  modport sink (
    input valid, input net_type, input transport_proto,
    input source_upper, input source_lower, input dest_upper, input dest_lower,
    input source_port, input dest_port, input frame_length, input header_short,
    output ready
  );
endinterface

>>> hdl/fkx_in_stage.sv
// Input register for frame bytes with the advance decision.
module fkx_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [7:0]        data_i,
  input  logic              last_i,
  input  logic              out_free_i,
  output logic              ready_o,
  output logic              proc_o,
  output fkx_pkg::fkx_byte_t byte_o
);
  import fkx_pkg::*;

  logic      valid_q;
  fkx_byte_t byte_q;

  // a last byte waits for room in the result register
  assign proc_o  = valid_q && (!byte_q.last || out_free_i);
  assign ready_o = !valid_q || proc_o;
  assign byte_o  = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q.data <= data_i;
      byte_q.last <= last_i;
    end
  end

endmodule

>>> hdl/fkx_capture.sv
// Per-frame parse state: byte counter, ethertype and header field capture.
module fkx_capture (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                proc_i,
  input  fkx_pkg::fkx_byte_t  byte_i,
  output fkx_pkg::fkx_state_t st_o
);
  import fkx_pkg::*;

  fkx_state_t st_q;
  fkx_state_t st_d;
  cnt_t       pos;
  logic [7:0] b;
  logic [3:0] ihl_eff;
  logic       is_v4;
  logic       is_v6;
  cnt_t       port_start;
  cnt_t       port_off;
  logic       port_hit;

  assign pos   = st_q.pos;
  assign b     = byte_i.data;
  assign is_v4 = (st_q.eth_type == TYPE_IPV4);
  assign is_v6 = (st_q.eth_type == TYPE_IPV6);

  // IHL is usable on the very byte that carries it
  assign ihl_eff    = (pos == cnt_t'(ETH_HDR_LEN)) ? b[3:0] : st_q.ihl;
  assign port_start = is_v4 ? cnt_t'(ETH_HDR_LEN) + cnt_t'({ihl_eff, 2'b00})
                            : cnt_t'(IPV6_PORTS);
  assign port_off   = pos - port_start;
  assign port_hit   = (pos >= port_start) && (port_off < cnt_t'(WORD_BYTES))
                      && (pos >= cnt_t'(ETH_HDR_LEN)) && (is_v4 || is_v6);

  always_comb begin
    st_d     = st_q;
    st_d.pos = (pos == CNT_MAX) ? pos : pos + cnt_t'(1);

    if (pos < cnt_t'(MAC_LEN)) begin
      st_d.dst_lo = {st_q.dst_lo[55:0], b};
    end else if (pos < cnt_t'(2 * MAC_LEN)) begin
      st_d.src_lo = {st_q.src_lo[55:0], b};
    end else if (pos == cnt_t'(POS_TYPE_HI)) begin
      st_d.eth_type = {b, 8'h00};
    end else if (pos == cnt_t'(POS_TYPE_LO)) begin
      st_d.eth_type = {st_q.eth_type[15:8], b};
      // IP frames reuse the low address registers
      if (st_d.eth_type == TYPE_IPV4 || st_d.eth_type == TYPE_IPV6) begin
        st_d.src_lo = '0;
        st_d.dst_lo = '0;
      end
    end else if (is_v4) begin
      st_d.ihl = ihl_eff;
      if (pos == cnt_t'(V4_PROTO)) st_d.proto = b;
      if (in_window(pos, V4_SRC, V4_SRC + 3)) st_d.src_lo = {st_q.src_lo[55:0], b};
      if (in_window(pos, V4_DST, V4_DST + 3)) st_d.dst_lo = {st_q.dst_lo[55:0], b};
    end else if (is_v6) begin
      if (pos == cnt_t'(V6_PROTO)) st_d.proto = b;
      if (in_window(pos, V6_SRC_HI, V6_SRC_HI + 7)) st_d.src_hi = {st_q.src_hi[55:0], b};
      if (in_window(pos, V6_SRC_LO, V6_SRC_LO + 7)) st_d.src_lo = {st_q.src_lo[55:0], b};
      if (in_window(pos, V6_DST_HI, V6_DST_HI + 7)) st_d.dst_hi = {st_q.dst_hi[55:0], b};
      if (in_window(pos, V6_DST_LO, V6_DST_LO + 7)) st_d.dst_lo = {st_q.dst_lo[55:0], b};
    end

    if (port_hit) begin
      if (!port_off[1]) st_d.sport = {st_q.sport[7:0], b};
      else              st_d.dport = {st_q.dport[7:0], b};
      if (port_off[1:0] == 2'd3) st_d.ports_done = 1'b1;
    end
  end

  assign st_o = st_d;

  // frame close returns everything to the reset state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (proc_i) begin
      st_q <= byte_i.last ? '0 : st_d;
    end
  end

endmodule

>>> hdl/fkx_result.sv
// Flow key assembly and output register.
module fkx_result (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  fkx_pkg::fkx_state_t st_i,
  input  logic                ready_i,
  output logic                valid_o,
  output logic                out_free_o,
  output fkx_pkg::fkx_key_t   key_o
);
  import fkx_pkg::*;

  localparam int WIDE_W = COUNT_BITS + 16;

  logic                valid_q;
  fkx_key_t            key_q;
  fkx_key_t            key_d;
  cnt_t                n;
  logic [WIDE_W-1:0]   n_wide;
  logic                is4;
  logic                is6;
  logic                tu;
  logic                shrt;

  assign n      = st_i.pos;
  assign n_wide = WIDE_W'(n);
  assign is4    = (n >= cnt_t'(ETH_HDR_LEN)) && (st_i.eth_type == TYPE_IPV4);
  assign is6    = (n >= cnt_t'(ETH_HDR_LEN)) && (st_i.eth_type == TYPE_IPV6);

  always_comb begin
    key_d = '0;
    shrt  = 1'b0;
    if (is4) begin
      key_d.net_type = TYPE_IPV4;
      if (n >= cnt_t'(V4_PROTO + 1)) key_d.transport_proto = st_i.proto;
      if (n >= cnt_t'(V4_SRC + 4))   key_d.source_lower = {32'h0, st_i.src_lo[31:0]};
      if (n >= cnt_t'(V4_END))       key_d.dest_lower   = {32'h0, st_i.dst_lo[31:0]};
      shrt = (n < cnt_t'(V4_END));
    end else if (is6) begin
      key_d.net_type = TYPE_IPV6;
      if (n >= cnt_t'(V6_PROTO + 1))  key_d.transport_proto = st_i.proto;
      if (n >= cnt_t'(V6_SRC_HI + 8)) key_d.source_upper = st_i.src_hi;
      if (n >= cnt_t'(V6_SRC_LO + 8)) key_d.source_lower = st_i.src_lo;
      if (n >= cnt_t'(V6_DST_HI + 8)) key_d.dest_upper   = st_i.dst_hi;
      if (n >= cnt_t'(IPV6_PORTS))    key_d.dest_lower   = st_i.dst_lo;
      shrt = (n < cnt_t'(IPV6_PORTS));
    end else begin
      if (n >= cnt_t'(MAC_LEN))     key_d.dest_lower   = {16'h0, st_i.dst_lo[47:0]};
      if (n >= cnt_t'(2 * MAC_LEN)) key_d.source_lower = {16'h0, st_i.src_lo[47:0]};
      shrt = (n < cnt_t'(ETH_HDR_LEN));
    end

    tu = (is4 || is6) &&
         (key_d.transport_proto == PROTO_TCP || key_d.transport_proto == PROTO_UDP);
    if (tu) begin
      if (st_i.ports_done) begin
        key_d.source_port = st_i.sport;
        key_d.dest_port   = st_i.dport;
      end else begin
        shrt = 1'b1;
      end
    end

    key_d.frame_length = (n_wide > WIDE_W'(LEN_MAX)) ? LEN_MAX : n_wide[15:0];
    key_d.header_short = shrt;
  end

  assign out_free_o = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign key_o      = key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      key_q <= key_d;
    end
  end

endmodule

>>> hdl/packet_flow_key_extractor_top.sv
// Top level of the packet flow key extractor.
//
// Takes one captured Ethernet frame as a stream of byte transactions on
// frame_i, starting at the destination MAC, with frame_last on the final
// byte, and returns one flow key transaction on key_o per frame. IPv4
// (0x0800) frames give the 32-bit addresses, protocol and, for TCP/UDP,
// the ports found after the IHL-sized header; IPv6 (0x86DD) frames give
// the 128-bit addresses as upper/lower halves, next header and ports at
// byte 54; any other ethertype gives the two MACs with net_type 0. Fields
// the frame ends before reaching read zero and raise header_short. The
// byte count saturates at 2^COUNT_BITS - 1 and frame_length at 65535.
// Throughput: one byte per clock with no gap between frames, save for the
// stall below. A byte is held in the input register, then updates the
// parse state; when the last byte leaves the input register, the key is
// loaded into the output register and key_o.valid rises, holding the key
// until it is taken. The only stall is a last byte arriving while the
// previous key still waits in the output register; then frame_i holds off
// until key_o is taken.
module packet_flow_key_extractor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  fkx_frame_if.sink   frame_i,
  fkx_key_if.source   key_o
);
  import fkx_pkg::*;

  logic       proc;        // byte in the input register is consumed
  logic       out_free;    // output register can take a key this cycle
  logic       key_valid;
  fkx_byte_t  cur_byte;
  fkx_state_t st_next;     // parse state including the current byte
  fkx_key_t   key;

  // Input register: one byte deep, refills in the cycle it drains.
  fkx_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (frame_i.valid),
    .data_i     (frame_i.frame_byte),
    .last_i     (frame_i.frame_last),
    .out_free_i (out_free),
    .ready_o    (frame_i.ready),
    .proc_o     (proc),
    .byte_o     (cur_byte)
  );

  // Parse state: counter, ethertype, address shift registers, ports.
  fkx_capture u_capture (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .proc_i (proc),
    .byte_i (cur_byte),
    .st_o   (st_next)
  );

  // Key assembly from the final state, held until the sink takes it.
  fkx_result u_result (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (proc && cur_byte.last),
    .st_i       (st_next),
    .ready_i    (key_o.ready),
    .valid_o    (key_valid),
    .out_free_o (out_free),
    .key_o      (key)
  );

  assign key_o.valid           = key_valid;
  assign key_o.net_type        = key.net_type;
  assign key_o.transport_proto = key.transport_proto;
  assign key_o.source_upper    = key.source_upper;
  assign key_o.source_lower    = key.source_lower;
  assign key_o.dest_upper      = key.dest_upper;
  assign key_o.dest_lower      = key.dest_lower;
  assign key_o.source_port     = key.source_port;
  assign key_o.dest_port       = key.dest_port;
  assign key_o.frame_length    = key.frame_length;
  assign key_o.header_short    = key.header_short;

endmodule

>>> hdl/fkx_checker.sv
// Port-level checker for the flow key extractor and its bind.
`include "assert_macros.svh"

module fkx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        key_valid_i,
  input logic        key_ready_i,
  input logic [15:0] key_net_type_i,
  input logic [7:0]  key_proto_i,
  input logic [63:0] key_src_upper_i,
  input logic [63:0] key_dst_upper_i,
  input logic [15:0] key_sport_i,
  input logic [15:0] key_dport_i,
  input logic [15:0] key_length_i,
  input logic        key_short_i
);
  import fkx_pkg::*;

  logic key_stall;
  logic type_known;
  logic non_ip;
  logic ip_fields_zero;
  logic runt;
  logic runt_flagged;

  assign key_stall      = key_valid_i && !key_ready_i;
  assign type_known     = (key_net_type_i == 16'h0000) || (key_net_type_i == TYPE_IPV4)
                          || (key_net_type_i == TYPE_IPV6);
  assign non_ip         = key_valid_i && (key_net_type_i == 16'h0000);
  assign ip_fields_zero = (key_proto_i == 8'd0) && (key_src_upper_i == 64'd0)
                          && (key_dst_upper_i == 64'd0) && (key_sport_i == 16'd0)
                          && (key_dport_i == 16'd0);
  assign runt           = (key_length_i < 16'd14);
  assign runt_flagged   = key_short_i && (key_net_type_i == 16'h0000);

  // a pending key stays until taken
  `FKX_ASSERT(a_key_hold, key_stall |=> key_valid_i, "key dropped while stalled")

  // every frame has at least its last byte
  `FKX_ASSERT_IMPLIES(a_len_nonzero, key_valid_i, key_length_i != 16'd0, "zero frame length")

  `FKX_ASSERT_IMPLIES(a_type_code, key_valid_i, type_known, "unexpected net type")

  // non-IP keys carry only MACs
  `FKX_ASSERT_IMPLIES(a_non_ip_clean, non_ip, ip_fields_zero, "non-IP key has IP fields")

  // no ethertype before byte 14
  `FKX_ASSERT_IMPLIES(a_runt_short, key_valid_i && runt, runt_flagged, "runt frame not flagged")

endmodule

bind packet_flow_key_extractor_top fkx_checker u_fkx_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .key_valid_i     (key_o.valid),
  .key_ready_i     (key_o.ready),
  .key_net_type_i  (key_o.net_type),
  .key_proto_i     (key_o.transport_proto),
  .key_src_upper_i (key_o.source_upper),
  .key_dst_upper_i (key_o.dest_upper),
  .key_sport_i     (key_o.source_port),
  .key_dport_i     (key_o.dest_port),
  .key_length_i    (key_o.frame_length),
  .key_short_i     (key_o.header_short)
);
